// ===== hdl/upgfc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// upgfc_pkg
// Shared types and constants of the upgrade frame checker.
// ----------------------------------------------------------------------------
package upgfc_pkg;

    localparam int COUNT_W = 10;

    localparam logic [7:0] SOF_BYTE   = 8'h72;
    localparam logic [7:0] START_BYTE = 8'h68;
    localparam logic [7:0] DATA_BYTE  = 8'h69;
    localparam logic [7:0] ABORT_BYTE = 8'hAA;
    localparam logic [7:0] EOF_BYTE   = 8'h16;

    localparam logic [COUNT_W-1:0] FRAME_LEN    = 10'd262;
    localparam logic [COUNT_W-1:0] START_LEN    = 10'd5;
    localparam logic [COUNT_W-1:0] ABORT_MINLEN = 10'd6;
    localparam logic [COUNT_W-1:0] HEAD_LEN     = 10'd4;
    localparam logic [COUNT_W-1:0] CHECK_POS    = 10'd260;

    localparam logic [31:0] FLASH_BASE    = 32'h0800_0000;
    localparam logic [8:0]  PAYLOAD_BYTES = 9'd256;

    typedef enum logic [1:0] {
        REPLY_ABORT  = 2'd0,
        REPLY_START  = 2'd1,
        REPLY_PACKET = 2'd2,
        REPLY_NAK    = 2'd3
    } reply_t;

    typedef enum logic [1:0] {
        CFG_APP_BASE    = 2'd0,
        CFG_FLASH_END   = 2'd1,
        CFG_PAGE_BYTES  = 2'd2,
        CFG_FLASH_VALID = 2'd3
    } cfg_idx_t;

    // status of the page remainder unit
    typedef struct packed {
        logic        busy;
        logic [31:0] addr;      // app_base + (packet - 1) * 256
        logic [11:0] rem_addr;  // addr % page_bytes
        logic [11:0] rem_off;   // (addr - app_base) % page_bytes
    } pgmod_res_t;

endpackage : upgfc_pkg
`default_nettype wire

// ===== hdl/upgrade_frame_checker.sv =====
`default_nettype none
// A byte is held in the input register; its reply, if any, is written to the result
//   register as the byte advances. Throughput: one byte per cycle while replies are taken.
//   The final byte of a 262-byte frame waits while the page remainders are unsettled,
//   as after a config write in the frame (the serial page remainder unit restarts on every config write).
// Reset: synchronous, active low; clears mode, counters, header and XOR state and
//   loads the register defaults. No clearing pass.
// ----------------------------------------------------------------------------
// upgrade_frame_checker
// Frame checker of a firmware upgrade link: start, abort and data frames,
// XOR, packet range and flash bound checks, one reply per answered frame.
// ----------------------------------------------------------------------------
module upgrade_frame_checker #(
    parameter int RX_BUFFER_BYTES = 512
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config write port
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [31:0] cfg_wr_data,
    // byte stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tlast,   // frame_last
    // replies out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata    // [1:0] reply_kind, [17:2] packet_number,
                                        // [49:18] wr_addr, [50] write_enable,
                                        // [51] erase_page, [52] upgrade_complete,
                                        // [53] fault, [55:54] zero
);
    import upgfc_pkg::*;

    localparam logic [COUNT_W-1:0] RX_CNT = COUNT_W'(RX_BUFFER_BYTES);

    // ---- configuration registers
    logic [31:0] app_base_reg;
    logic [31:0] flash_end_reg;
    logic [11:0] page_bytes_reg;
    logic        flash_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            app_base_reg    <= 32'h0800_4000;
            flash_end_reg   <= 32'h0801_0000;
            page_bytes_reg  <= 12'd1024;
            flash_valid_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_APP_BASE:    app_base_reg    <= cfg_wr_data;
                CFG_FLASH_END:   flash_end_reg   <= cfg_wr_data;
                CFG_PAGE_BYTES:  page_bytes_reg  <= cfg_wr_data[11:0];
                CFG_FLASH_VALID: flash_valid_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // ---- input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // ---- frame state
    logic               mode_reg;       // 0 idle, 1 upgrade
    logic [15:0]        total_reg;
    logic [COUNT_W-1:0] byte_count_reg;
    logic [7:0]         head_reg [4];
    logic [7:0]         xor_reg;
    logic [7:0]         check_reg;
    logic               div_req_reg;    // remainder unit to be (re)started

    // ---- result register
    logic        out_valid_reg;
    reply_t      kind_reg;
    logic [15:0] num_reg;
    logic [31:0] addr_reg;
    logic        we_reg;
    logic        erase_reg;
    logic        done_reg;
    logic        fault_reg;

    pgmod_res_t pg;

    // ---- step logic
    logic               adv;
    logic               stall;
    logic               sat;
    logic [COUNT_W-1:0] len;
    logic [15:0]        num;
    logic               abort_ok;
    logic               start_ok;
    logic               emit;
    logic               range_pl;
    logic               range_pg;
    logic               erase;
    reply_t             kind_next;
    logic [15:0]        num_next;
    logic [31:0]        addr_next;
    logic               we_next;
    logic               erase_next;
    logic               done_next;
    logic               fault_next;

    assign sat = (byte_count_reg >= RX_CNT);
    assign len = sat ? byte_count_reg : byte_count_reg + 1'b1;
    assign num = {head_reg[2], head_reg[3]};

    // header bytes are complete whenever a length check passes
    assign abort_ok = (len >= ABORT_MINLEN) && (head_reg[0] == SOF_BYTE) &&
                      (head_reg[1] == START_BYTE) && (head_reg[2] == ABORT_BYTE) &&
                      (in_byte_reg == EOF_BYTE);
    assign start_ok = !mode_reg && (len == START_LEN) && (head_reg[0] == SOF_BYTE) &&
                      (head_reg[1] == START_BYTE) && (in_byte_reg == EOF_BYTE);
    assign emit = in_last_reg && (start_ok || abort_ok || mode_reg);

    // a full-length data frame needs the page remainders settled
    assign stall = in_last_reg && (len == FRAME_LEN) && (div_req_reg || pg.busy);
    assign adv   = in_valid_reg && (!out_valid_reg || m_tready) && !stall;
    assign s_tready = !in_valid_reg || adv;

    // flash bounds, compared one bit wider so sums do not wrap
    assign range_pl = flash_valid_reg && (pg.addr >= FLASH_BASE) &&
                      ({1'b0, pg.addr} + 33'(PAYLOAD_BYTES) <= {1'b0, flash_end_reg});
    assign range_pg = flash_valid_reg && (pg.addr >= FLASH_BASE) &&
                      ({1'b0, pg.addr} + 33'(page_bytes_reg) <= {1'b0, flash_end_reg});
    assign erase = (pg.rem_off == 12'd0);

    always_comb begin
        kind_next  = REPLY_NAK;
        num_next   = '0;
        addr_next  = '0;
        we_next    = 1'b0;
        erase_next = 1'b0;
        done_next  = 1'b0;
        fault_next = 1'b0;
        if (start_ok) begin
            kind_next = REPLY_START;
        end else if (abort_ok) begin
            kind_next = REPLY_ABORT;
        end else if (len != FRAME_LEN || head_reg[0] != SOF_BYTE ||
                     head_reg[1] != DATA_BYTE || in_byte_reg != EOF_BYTE) begin
            fault_next = 1'b0;                  // framing error
        end else if (xor_reg != check_reg || !flash_valid_reg ||
                     page_bytes_reg == 12'd0) begin
            fault_next = 1'b1;
        end else if (num == 16'd0 || num > total_reg) begin
            fault_next = 1'b1;
        end else if (!range_pl) begin
            fault_next = 1'b1;
        end else if (erase && (pg.rem_addr != 12'd0 || !range_pg)) begin
            fault_next = 1'b1;                  // page start not usable
        end else if (pg.addr[0]) begin
            fault_next = 1'b1;                  // odd address
        end else begin
            kind_next  = REPLY_PACKET;
            num_next   = num;
            addr_next  = pg.addr;
            we_next    = 1'b1;
            erase_next = erase;
            done_next  = (num == total_reg);
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= 1'b0;
            total_reg      <= '0;
            byte_count_reg <= '0;
            head_reg[0]    <= '0;
            head_reg[1]    <= '0;
            head_reg[2]    <= '0;
            head_reg[3]    <= '0;
            xor_reg        <= '0;
            check_reg      <= '0;
            div_req_reg    <= 1'b0;
        end else begin
            // restart after header complete or any register change
            div_req_reg <= cfg_wr_en ||
                           (adv && !in_last_reg && byte_count_reg == HEAD_LEN - 1'b1);
            if (adv) begin
                if (in_last_reg) begin
                    byte_count_reg <= '0;
                    head_reg[0]    <= '0;
                    head_reg[1]    <= '0;
                    head_reg[2]    <= '0;
                    head_reg[3]    <= '0;
                    xor_reg        <= '0;
                    check_reg      <= '0;
                    if (start_ok) begin
                        total_reg <= num;
                        mode_reg  <= 1'b1;
                    end else if (abort_ok) begin
                        mode_reg <= 1'b0;
                    end
                end else if (!sat) begin
                    byte_count_reg <= len;
                    if (byte_count_reg < HEAD_LEN) begin
                        head_reg[byte_count_reg[1:0]] <= in_byte_reg;
                    end else if (byte_count_reg < CHECK_POS) begin
                        xor_reg <= xor_reg ^ in_byte_reg;
                    end else if (byte_count_reg == CHECK_POS) begin
                        check_reg <= in_byte_reg;
                    end
                end
            end
        end
    end

    upgfc_pgmod u_pgmod (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (div_req_reg),
        .app_base   (app_base_reg),
        .pkt_num    (num),
        .page_bytes (page_bytes_reg),
        .res        (pg)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && emit) begin
            kind_reg  <= kind_next;
            num_reg   <= num_next;
            addr_reg  <= addr_next;
            we_reg    <= we_next;
            erase_reg <= erase_next;
            done_reg  <= done_next;
            fault_reg <= fault_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, fault_reg, done_reg, erase_reg, we_reg,
                       addr_reg, num_reg, kind_reg};

`ifndef ASSERT_OFF
    a_no_stale_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_last_reg && len == FRAME_LEN) |-> (!pg.busy && !div_req_reg))
        else $error("data frame closed while page remainders unsettled");
    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_last_reg) |=> (byte_count_reg == '0 && xor_reg == '0))
        else $error("frame state not cleared at frame end");
    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= RX_CNT)
        else $error("byte count beyond buffer size");
    a_we_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && we_reg) |-> (kind_reg == REPLY_PACKET && !fault_reg))
        else $error("write enable outside a packet ack");
`endif

endmodule : upgrade_frame_checker
`default_nettype wire

// ===== hdl/upgfc_pgmod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// upgfc_pgmod
// Write address of a packet and its two remainders by the page size,
// one remainder bit per cycle (restoring) once started.
// ----------------------------------------------------------------------------
module upgfc_pgmod (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [31:0]             app_base,
    input  wire logic [15:0]             pkt_num,
    input  wire logic [11:0]             page_bytes,
    output upgfc_pkg::pgmod_res_t        res
);
    import upgfc_pkg::*;

    localparam logic [5:0] DIV_STEPS = 6'd32;

    logic [5:0]  cnt_reg;
    logic [31:0] addr_reg;
    logic [31:0] qa_reg;
    logic [31:0] qb_reg;
    logic [11:0] ra_reg;
    logic [11:0] rb_reg;
    logic [11:0] d_reg;

    logic [23:0] offset;
    logic [31:0] addr_start;
    logic [12:0] ta;
    logic [12:0] tb;
    logic [11:0] ra_next;
    logic [11:0] rb_next;

    assign offset     = {16'(pkt_num - 16'd1), 8'h00};
    assign addr_start = app_base + {8'h00, offset};

    assign ta = {ra_reg, qa_reg[31]};
    assign tb = {rb_reg, qb_reg[31]};
    assign ra_next = (ta >= {1'b0, d_reg}) ? 12'(ta - {1'b0, d_reg}) : ta[11:0];
    assign rb_next = (tb >= {1'b0, d_reg}) ? 12'(tb - {1'b0, d_reg}) : tb[11:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= DIV_STEPS;
        end else if (cnt_reg != 6'd0) begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            addr_reg <= addr_start;
            qa_reg   <= addr_start;
            qb_reg   <= {8'h00, offset};
            ra_reg   <= '0;
            rb_reg   <= '0;
            d_reg    <= page_bytes;
        end else if (cnt_reg != 6'd0) begin
            qa_reg <= {qa_reg[30:0], 1'b0};
            qb_reg <= {qb_reg[30:0], 1'b0};
            ra_reg <= ra_next;
            rb_reg <= rb_next;
        end
    end

    assign res.busy     = (cnt_reg != 6'd0);
    assign res.addr     = addr_reg;
    assign res.rem_addr = ra_reg;
    assign res.rem_off  = rb_reg;

`ifndef ASSERT_OFF
    a_start_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> cnt_reg == DIV_STEPS)
        else $error("remainder unit did not load its step count");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= DIV_STEPS)
        else $error("remainder step count out of range");
    a_cnt_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != 6'd0 && !start) |=> cnt_reg == $past(cnt_reg) - 6'd1)
        else $error("remainder step count skipped");
`endif

endmodule : upgfc_pgmod
`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Upgrade frame checker testbench
// Drives byte frames (start, abort, data, malformed and noise frames) into the
// frame checker, predicts every reply from a behavioral copy of the checker
// and compares the reply stream in order, under several flash settings and
// with random idle cycles on both sides of the block.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import upgfc_pkg::*;

    localparam int RX_BYTES     = 512;  // receive buffer depth of the instance
    localparam int DRAIN_CYCLES = 40;   // pipeline plus page remainder restart
    localparam int HOLD_CYCLES  = 600;  // long receiver hold-off

    // one received byte and its end-of-frame mark
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rx_item_s;

    // reply layout, lowest field in the lowest bits
    typedef struct packed {
        logic [1:0]  pad;
        logic        fault;
        logic        done;
        logic        erase;
        logic        wr_en;
        logic [31:0] wr_addr;
        logic [15:0] pkt_num;
        reply_t      kind;
    } reply_s;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    always #2 aclk = ~aclk;

    upgrade_frame_checker #(
        .RX_BUFFER_BYTES(RX_BYTES)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // ------------------------------------------------------------------
    // Stimulus and scoreboard storage
    // ------------------------------------------------------------------
    rx_item_s tx_bytes[$];     // items waiting for the driver
    reply_s   replies_due[$];  // predicted replies, oldest first

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic hold_request = 1'b0;
    logic hold_off     = 1'b0;

    int bytes_queued  = 0;
    int bytes_taken   = 0;
    int frames_sent   = 0;
    int replies_seen  = 0;
    int acks_seen     = 0;
    int faults_seen   = 0;
    int settings_used = 0;
    int mismatches    = 0;

    // ------------------------------------------------------------------
    // Behavioral copy of the checker: register copies and frame state
    // ------------------------------------------------------------------
    logic [31:0] base_addr = 32'h0800_4000;
    logic [31:0] end_addr  = 32'h0801_0000;
    logic [11:0] page_size = 12'd1024;
    logic        geom_ok   = 1'b1;

    logic        mode_upgrade = 1'b0;
    logic [15:0] pkt_total = '0;
    logic [9:0]  rx_count = '0;
    logic [7:0]  hdr [4] = '{default: 8'h00};
    logic [7:0]  run_xor = '0;
    logic [7:0]  chk_byte = '0;

    // region check; the sum is taken one bit wider so it never wraps
    function automatic logic fits(input logic [31:0] addr, input logic [11:0] len);
        return geom_ok && addr >= FLASH_BASE &&
               ({1'b0, addr} + 33'(len)) <= {1'b0, end_addr};
    endfunction

    // reply to a frame in upgrade mode that is not an abort
    function automatic reply_s packet_reply(input logic [7:0] eof);
        reply_s      r;
        logic [15:0] num;
        logic [31:0] addr;
        logic        erase;
        r = '0;
        r.kind = REPLY_NAK;
        if (rx_count != FRAME_LEN || hdr[0] != SOF_BYTE || hdr[1] != DATA_BYTE ||
            eof != EOF_BYTE)
            return r;
        // well framed from here on: every refusal is a fault
        r.fault = 1'b1;
        num = {hdr[2], hdr[3]};
        if (run_xor != chk_byte || !geom_ok || page_size == 0)
            return r;
        if (num == 0 || num > pkt_total)
            return r;
        addr = base_addr + ((32'(num) - 32'd1) << 8);
        if (!fits(addr, 12'd256))
            return r;
        // page boundary counted from the application base
        erase = ((addr - base_addr) % page_size) == 0;
        if (erase && ((addr % page_size) != 0 || !fits(addr, page_size)))
            return r;
        if (addr[0])
            return r;
        r = '0;
        r.kind    = REPLY_PACKET;
        r.pkt_num = num;
        r.wr_addr = addr;
        r.wr_en   = 1'b1;
        r.erase   = erase;
        r.done    = (num == pkt_total);
        return r;
    endfunction

    // advance the frame state by one byte; returns 1 when a reply is due
    function automatic logic track_byte(input logic [7:0] b, input logic fl,
                                        output reply_s r);
        logic abort_hit;
        logic has;
        r = '0;
        if (rx_count < RX_BYTES) begin
            if (rx_count < HEAD_LEN)
                hdr[rx_count[1:0]] = b;
            else if (rx_count < CHECK_POS)
                run_xor = run_xor ^ b;
            else if (rx_count == CHECK_POS)
                chk_byte = b;
            rx_count = rx_count + 10'd1;
        end
        if (!fl)
            return 1'b0;
        abort_hit = rx_count >= ABORT_MINLEN && hdr[0] == SOF_BYTE &&
                    hdr[1] == START_BYTE && hdr[2] == ABORT_BYTE && b == EOF_BYTE;
        has = 1'b1;
        if (!mode_upgrade) begin
            if (rx_count == START_LEN && hdr[0] == SOF_BYTE && hdr[1] == START_BYTE &&
                b == EOF_BYTE) begin
                pkt_total = {hdr[2], hdr[3]};
                mode_upgrade = 1'b1;
                r.kind = REPLY_START;
            end else if (abort_hit) begin
                r.kind = REPLY_ABORT;
            end else begin
                has = 1'b0;  // idle mode ignores anything else
            end
        end else if (abort_hit) begin
            mode_upgrade = 1'b0;
            r.kind = REPLY_ABORT;
        end else begin
            r = packet_reply(b);
        end
        rx_count = '0;
        hdr = '{default: 8'h00};
        run_xor = '0;
        chk_byte = '0;
        return has;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers the next queued item once the current one is taken
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                {s_tdata, s_tlast} <= tx_bytes.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver readiness; a hold-off overrides the random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long hold-off so that replies pile up and the input stalls
    initial begin
        wait (hold_request);
        @(negedge aclk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        hold_off = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: register copies, reply check, prediction per accepted item
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        reply_s got;
        reply_s want;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_APP_BASE:    base_addr = cfg_wr_data;
                    CFG_FLASH_END:   end_addr  = cfg_wr_data;
                    CFG_PAGE_BYTES:  page_size = cfg_wr_data[11:0];
                    CFG_FLASH_VALID: geom_ok   = cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = reply_s'(m_tdata);
                replies_seen++;
                if (got.kind == REPLY_PACKET)
                    acks_seen++;
                if (got.fault)
                    faults_seen++;
                if (replies_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected reply kind %0d num %0h addr %h",
                                 $realtime, got.kind, got.pkt_num, got.wr_addr);
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    if (got.kind !== want.kind || got.pkt_num !== want.pkt_num ||
                        got.wr_addr !== want.wr_addr || got.wr_en !== want.wr_en ||
                        got.erase !== want.erase || got.done !== want.done ||
                        got.fault !== want.fault || got.pad !== want.pad) begin
                        if (mismatches < 10) begin
                            $display("%0t: reply mismatch", $realtime);
                            $display("  want kind %0d num %h addr %h we %b er %b done %b flt %b pad %b",
                                     want.kind, want.pkt_num, want.wr_addr, want.wr_en,
                                     want.erase, want.done, want.fault, want.pad);
                            $display("  got  kind %0d num %h addr %h we %b er %b done %b flt %b pad %b",
                                     got.kind, got.pkt_num, got.wr_addr, got.wr_en,
                                     got.erase, got.done, got.fault, got.pad);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                bytes_taken++;
                if (track_byte(s_tdata, s_tlast, want))
                    replies_due.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------
    // Frame builders
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic fl);
        tx_bytes.push_back({b, fl});
        bytes_queued++;
        if (fl)
            frames_sent++;
    endtask

    task automatic put_start(input logic [15:0] total, input logic [7:0] eof);
        push_byte(SOF_BYTE, 1'b0);
        push_byte(START_BYTE, 1'b0);
        push_byte(total[15:8], 1'b0);
        push_byte(total[7:0], 1'b0);
        push_byte(eof, 1'b1);
    endtask

    // len counts the whole frame, at least six bytes
    task automatic put_abort(input int len);
        push_byte(SOF_BYTE, 1'b0);
        push_byte(START_BYTE, 1'b0);
        push_byte(ABORT_BYTE, 1'b0);
        repeat (len - 4) push_byte(8'($urandom()), 1'b0);
        push_byte(EOF_BYTE, 1'b1);
    endtask

    task automatic put_noise(input int len);
        repeat (len - 1) push_byte(8'($urandom()), 1'b0);
        push_byte(8'($urandom()), 1'b1);
    endtask

    // data frame of len bytes; the final byte is always eof, flip corrupts the XOR
    task automatic put_packet(input logic [15:0] num, input int len, input logic [7:0] id,
                              input logic [7:0] eof, input logic [7:0] flip);
        logic [7:0] acc;
        logic [7:0] b;
        acc = '0;
        for (int p = 0; p < len; p++) begin
            if (p == len - 1) begin
                b = eof;
            end else if (p == 0) begin
                b = SOF_BYTE;
            end else if (p == 1) begin
                b = id;
            end else if (p == 2) begin
                b = num[15:8];
            end else if (p == 3) begin
                b = num[7:0];
            end else if (p < CHECK_POS) begin
                b = 8'($urandom());
                acc = acc ^ b;
            end else if (p == CHECK_POS) begin
                b = acc ^ flip;
            end else begin
                b = 8'($urandom());
            end
            push_byte(b, p == len - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------
    // all items taken, all replies in, pipeline and remainder unit quiet
    task automatic settle();
        while (bytes_taken != bytes_queued || replies_due.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
    endtask

    task automatic set_flash(input logic [31:0] base, input logic [31:0] top,
                             input logic [11:0] page, input logic ok);
        write_reg(CFG_APP_BASE, base);
        write_reg(CFG_FLASH_END, top);
        write_reg(CFG_PAGE_BYTES, 32'(page));
        write_reg(CFG_FLASH_VALID, 32'(ok));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // no idling, reset settings: idle frames, start, first page, framing errors
        push_byte(8'hFF, 1'b1);                                  // idle noise: ignored
        put_abort(6);                                            // abort while idle
        put_start(16'd3, 8'h15);                                 // bad start end byte
        put_start(16'd3, EOF_BYTE);                              // enter upgrade, total 3
        put_packet(16'd1, FRAME_LEN, DATA_BYTE, EOF_BYTE, 8'h00); // first page: erase
        put_noise(7);                                            // garbage in upgrade
        put_packet(16'd2, 12, DATA_BYTE, EOF_BYTE, 8'h00);       // short frame
        settle();

        // sender mostly idle: last packet mid page, more framing errors
        send_idle_pct = 87;
        recv_stall_pct = 0;
        put_packet(16'd3, FRAME_LEN, DATA_BYTE, EOF_BYTE, 8'h00); // last packet: done
        put_packet(16'd3, 10, 8'h6A, EOF_BYTE, 8'h00);           // wrong type byte
        put_start(16'd4, EOF_BYTE);                              // start in upgrade: nak
        settle();

        // receiver mostly stalling: base off a page boundary, unaligned erase
        send_idle_pct = 0;
        recv_stall_pct = 87;
        set_flash(32'h0800_0100, 32'h0801_0000, 12'd1024, 1'b1);
        put_packet(16'd1, FRAME_LEN, DATA_BYTE, EOF_BYTE, 8'h00);
        put_abort(9);                                            // abort in upgrade
        put_packet(16'd1, 8, DATA_BYTE, EOF_BYTE, 8'h00);        // idle: ignored
        settle();

        // both sides idle now and then; short frames while the receiver holds off
        send_idle_pct = 17;
        recv_stall_pct = 17;
        set_flash(32'h0800_4000, 32'h0801_0000, 12'd1024, 1'b1);
        hold_request = 1'b1;
        repeat (10) begin
            put_start(16'($urandom_range(1, 6)), EOF_BYTE);
            put_abort($urandom_range(6, 10));
        end
        settle();

        $display("Run covered %0d frames (%0d bytes) under %0d flash settings.",
                 frames_sent, bytes_queued, settings_used);
        $display("Replies checked: %0d, packet acks %0d, faults %0d, mismatches %0d.",
                 replies_seen, acks_seen, faults_seen, mismatches);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // run limit, several times the slowest expected run
    initial begin
        #200_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
